@@ src/spq_pkg.sv @@
// Package with the shared types, field widths and codes of the sorted priority queue.
`default_nettype none

package spq_pkg;

    // Queue depth and field widths of the transfer payloads.
    localparam int SPQ_DEPTH          = 16;
    localparam int SPQ_VALUE_WIDTH    = 32;
    localparam int SPQ_PRIORITY_WIDTH = 16;
    localparam int SPQ_COUNT_WIDTH    = 5;
    localparam int SPQ_STATUS_WIDTH   = 2;

    // Operation codes.
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    // Status codes.
    localparam logic [SPQ_STATUS_WIDTH-1:0] ST_DONE  = 2'd0;
    localparam logic [SPQ_STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
    localparam logic [SPQ_STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

    // One stored entry.
    typedef struct packed {
        logic signed [SPQ_VALUE_WIDTH-1:0]    value;
        logic signed [SPQ_PRIORITY_WIDTH-1:0] prio;
    } t_entry;

    // Input item.
    typedef struct packed {
        logic                                 cmd;
        logic signed [SPQ_VALUE_WIDTH-1:0]    item_value;
        logic signed [SPQ_PRIORITY_WIDTH-1:0] item_priority;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic signed [SPQ_VALUE_WIDTH-1:0]    popped_value;
        logic signed [SPQ_PRIORITY_WIDTH-1:0] popped_priority;
        logic signed [SPQ_VALUE_WIDTH-1:0]    head_value;
        logic signed [SPQ_PRIORITY_WIDTH-1:0] head_priority;
        logic        [SPQ_COUNT_WIDTH-1:0]    entry_count;
        logic        [SPQ_STATUS_WIDTH-1:0]   status;
    } t_out_item;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ src/spq_cell.sv @@
// One cell of the sorted chain: holds an entry and compares, shifts or loads it.
`default_nettype none

module spq_cell (
    input  wire logic                i_clk,
    input  wire spq_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                i_occupied,
    input  wire logic                i_left_keep,
    input  wire spq_pkg::t_entry     i_left_entry,
    input  wire spq_pkg::t_entry     i_right_entry,
    output logic                     o_keep,
    output spq_pkg::t_entry          o_entry,
    output spq_pkg::t_entry          o_next_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // An occupied cell whose priority is at least the new one stays in place on a push.
    assign o_keep = i_occupied && (r_entry.prio >= i_ctrl.new_entry.prio);

    // Next content: hold, load the new entry, take the left one, or take the right one.
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.push) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_ctrl.new_entry;
            end else begin
                n_entry = i_left_entry;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right_entry;
        end
    end

    // Entry storage needs no reset; the fill count says which cells hold data.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry      = r_entry;
    assign o_next_entry = n_entry;

endmodule

`default_nettype wire

@@ src/sorted_priority_queue_top.sv @@
// Top level of the sorted priority queue: cell chain, fill count and result register.
//
// Usage: each input transfer carries one command. An enqueue stores item_value with
// item_priority behind every stored entry of greater or equal priority; a dequeue
// removes the head. Each input transfer produces exactly one result transfer that
// shows the removed entry (zero if none), the head after the operation (zero if
// empty), the entry count and a status code (done, enqueue dropped because full,
// dequeue on empty queue).
// The result is registered: it is valid in the cycle after the input transfer.
// Throughput is one item per cycle while the receiver does not stall. Every cell
// compares its own priority with the new one and moves in the same cycle, so the
// whole chain of DEPTH cells updates together; the result register is the only stage.
// When the receiver stalls, the result register holds and input ready drops until
// the result is taken; ready also stays high in a cycle where the waiting result
// leaves, so no cycle is lost.
// Reset clears the fill count and the result valid flag; the queue starts empty and
// the cell contents are not cleared.
`default_nettype none

module sorted_priority_queue_top #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire spq_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output spq_pkg::t_out_item     o_out_data
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out_item     r_out_data;
    t_out_item     n_out_data;

    logic          accept;
    logic          is_full;
    logic          is_empty;
    t_cell_ctrl    ctrl;

    logic   keep       [DEPTH];
    t_entry entry      [DEPTH];
    t_entry next_entry [DEPTH];

    // Input handshake: a new item enters whenever the result register is free or leaving.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign is_full  = (r_count == CW'(DEPTH));
    assign is_empty = (r_count == '0);

    // Control broadcast to the cells.
    always_comb begin
        ctrl.push            = accept && (i_in_data.cmd == CMD_ENQUEUE) && !is_full;
        ctrl.pop             = accept && (i_in_data.cmd == CMD_DEQUEUE) && !is_empty;
        ctrl.new_entry.value = i_in_data.item_value;
        ctrl.new_entry.prio  = i_in_data.item_priority;
    end

    // The chain of cells; cell 0 is the head.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic   occupied;
        logic   left_keep;
        t_entry left_entry;
        t_entry right_entry;

        assign occupied = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_keep  = 1'b1;
            assign left_entry = ctrl.new_entry;
        end else begin : g_body
            assign left_keep  = keep[g-1];
            assign left_entry = entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_entry = entry[g];
        end else begin : g_mid
            assign right_entry = entry[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occupied    (occupied),
            .i_left_keep   (left_keep),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .o_keep        (keep[g]),
            .o_entry       (entry[g]),
            .o_next_entry  (next_entry[g])
        );
    end

    // Fill count after the operation.
    always_comb begin
        n_count = r_count;
        if (ctrl.push) begin
            n_count = r_count + CW'(1);
        end else if (ctrl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // Result fields for the accepted item.
    always_comb begin
        n_out_data = '0;
        if (ctrl.pop) begin
            n_out_data.popped_value    = entry[0].value;
            n_out_data.popped_priority = entry[0].prio;
        end
        if (n_count != '0) begin
            n_out_data.head_value    = next_entry[0].value;
            n_out_data.head_priority = next_entry[0].prio;
        end
        n_out_data.entry_count = SPQ_COUNT_WIDTH'(n_count);
        if (accept && (i_in_data.cmd == CMD_ENQUEUE) && is_full) begin
            n_out_data.status = ST_FULL;
        end else if (accept && (i_in_data.cmd == CMD_DEQUEUE) && is_empty) begin
            n_out_data.status = ST_EMPTY;
        end else begin
            n_out_data.status = ST_DONE;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
